// ----- rtl/prf_pkg.sv -----
// Shared types and constants for the page replacement unit.
// No dependencies; imported by every module of the block.
package prf_pkg;

  // Register word indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_PAGE_SHIFT  = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] REG_POLICY      = 2'd2;

  localparam logic [4:0] PAGE_SHIFT_RST  = 5'd12;
  localparam logic [6:0] FRAME_COUNT_RST = 7'd64;
  localparam logic       POLICY_FIFO     = 1'b0;
  localparam logic       POLICY_LRU      = 1'b1;

  localparam int unsigned CNT_W   = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } prf_state_t;

  typedef struct packed {
    logic clear;  // start of a new word: drop previous scan results
    logic step;   // one frame entry is presented this cycle
  } scan_ctrl_t;

  typedef struct packed {
    logic hit_found;
    logic free_found;
  } scan_status_t;

endpackage

// ----- rtl/prf_frame_mem.sv -----
// Frame table memory: one write port, one registered read port.
// Depends on prf_pkg only by convention; no package items used beyond import.
module prf_frame_mem #(
  parameter int unsigned WIDTH = 75,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);
  import prf_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/prf_scan.sv -----
// Shared scan unit: takes one frame entry per cycle and keeps the hit match,
// the lowest free frame and the oldest-stamp victim. Uses prf_pkg types.
module prf_scan #(
  parameter int unsigned PAGE_BITS = 10,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IDX_BITS  = 6,
  parameter int unsigned NUM_BITS  = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prf_pkg::scan_ctrl_t           ctrl,
  input  logic [IDX_BITS-1:0]           idx,
  input  logic                          occ,
  input  logic [PAGE_BITS-1:0]          ent_page,
  input  logic                          ent_dirty,
  input  logic [TIME_BITS-1:0]          ent_load,
  input  logic [TIME_BITS-1:0]          ent_access,
  input  logic [PAGE_BITS-1:0]          page,
  input  logic                          policy,
  input  logic [NUM_BITS-1:0]           active,
  output prf_pkg::scan_status_t         status,
  output logic [IDX_BITS-1:0]           hit_idx,
  output logic                          hit_dirty,
  output logic [TIME_BITS-1:0]          hit_load,
  output logic [IDX_BITS-1:0]           free_idx,
  output logic [IDX_BITS-1:0]           victim_idx,
  output logic [PAGE_BITS-1:0]          victim_page,
  output logic                          victim_dirty
);
  import prf_pkg::*;

  logic                 have_victim;
  logic [TIME_BITS-1:0] best_time;
  logic [TIME_BITS-1:0] stamp;
  logic                 in_range;
  logic                 hit_take;
  logic                 free_take;
  logic                 vic_take;

  always_comb begin
    stamp     = (policy == POLICY_LRU) ? ent_access : ent_load;
    in_range  = NUM_BITS'(idx) < active;
    hit_take  = ctrl.step && occ && (ent_page == page);
    free_take = ctrl.step && in_range && !occ && !status.free_found;
    // strict less: ties keep the lower frame seen first
    vic_take  = ctrl.step && in_range && occ && (!have_victim || (stamp < best_time));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      status      <= '0;
      have_victim <= 1'b0;
    end else begin
      if (hit_take) status.hit_found <= 1'b1;
      if (free_take) status.free_found <= 1'b1;
      if (vic_take) have_victim <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_take) begin
      hit_idx   <= idx;
      hit_dirty <= ent_dirty;
      hit_load  <= ent_load;
    end
    if (free_take) begin
      free_idx <= idx;
    end
    if (vic_take) begin
      victim_idx   <= idx;
      victim_page  <= ent_page;
      victim_dirty <= ent_dirty;
      best_time    <= stamp;
    end
  end

endmodule

// ----- rtl/page_replacement_fifo_lru.sv -----
// Top level of the FIFO/LRU page replacement unit: register port, sequencer,
// counters and result register. Uses prf_pkg, prf_frame_mem and prf_scan.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, address, is_write      | into block
//   out     | out_valid, out_stall, hit, frame, evicted, | out of block
//           | evicted_page, evicted_dirty, pages_read,   |
//           | dirty_evictions                            |
//   cfg     | psel, penable, pwrite, paddr, pwdata,      | APB slave
//           | prdata, pready                             |
//
// The scan unit reads one frame entry per cycle for the hit lookup, free-frame
// search and victim. Reset clears the occupancy bits, counters and registers
// at once; the frame table needs no clearing pass since unoccupied entries are
// never used. A stalled result holds the block in its final step; one new word
// may be taken while the previous result waits.
module page_replacement_fifo_lru #(
  parameter int unsigned PAGE_NUM_BITS = 10,
  parameter int unsigned MAX_FRAMES    = 64,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] address,
  input  logic        is_write,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [5:0]  frame,
  output logic        evicted,
  output logic [9:0]  evicted_page,
  output logic        evicted_dirty,
  output logic [31:0] pages_read,
  output logic [31:0] dirty_evictions,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prf_pkg::*;

  localparam int unsigned IDX_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NUM_BITS = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_BITS = (NUM_BITS > 7) ? NUM_BITS : 7;
  localparam int unsigned ENT_BITS = PAGE_NUM_BITS + 1 + 2 * TIME_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // configuration registers
  logic [4:0] page_shift;
  logic [6:0] frame_count;
  logic       policy;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift  <= PAGE_SHIFT_RST;
      frame_count <= FRAME_COUNT_RST;
      policy      <= POLICY_FIFO;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PAGE_SHIFT:  page_shift  <= pwdata[4:0];
        REG_FRAME_COUNT: frame_count <= pwdata[6:0];
        REG_POLICY:      policy      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PAGE_SHIFT:  prdata = 32'(page_shift);
      REG_FRAME_COUNT: prdata = 32'(frame_count);
      REG_POLICY:      prdata = 32'(policy);
      default:         prdata = '0;
    endcase
  end

  // frames in use: zero acts as one, clamp at MAX_FRAMES
  logic [NUM_BITS-1:0] active;
  always_comb begin
    if (frame_count == 7'd0) begin
      active = NUM_BITS'(1);
    end else if (CMP_BITS'(frame_count) > CMP_BITS'(MAX_FRAMES)) begin
      active = NUM_BITS'(MAX_FRAMES);
    end else begin
      active = NUM_BITS'(frame_count);
    end
  end

  // sequencer
  prf_state_t state, state_next;
  logic [IDX_BITS:0]        issue_cnt;
  logic                     issuing;
  logic                     rd_vld;
  logic [IDX_BITS-1:0]      rd_idx;
  logic                     occ_q;
  logic                     accept;
  logic                     done_fire;
  scan_ctrl_t               scan_ctrl;
  scan_status_t             scan_st;

  logic [PAGE_NUM_BITS-1:0] cur_page;
  logic                     cur_write;
  logic [TIME_BITS-1:0]     clock_count;
  logic [31:0]              miss_count;
  logic [31:0]              dirty_evict_count;
  logic [MAX_FRAMES-1:0]    occupied;

  assign accept  = in_valid && !in_stall;
  assign issuing = (state == ST_SCAN) && (issue_cnt < (IDX_BITS+1)'(MAX_FRAMES));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (rd_vld && (issue_cnt == (IDX_BITS+1)'(MAX_FRAMES))) state_next = ST_DONE;
      end
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != ST_IDLE);
    scan_ctrl.clear = accept;
    scan_ctrl.step  = rd_vld;
    done_fire       = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issuing;
      if (accept) begin
        issue_cnt <= '0;
      end else if (issuing) begin
        issue_cnt <= issue_cnt + (IDX_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_page  <= PAGE_NUM_BITS'(address >> page_shift);
      cur_write <= is_write;
    end
    rd_idx <= issue_cnt[IDX_BITS-1:0];
    occ_q  <= occupied[issue_cnt[IDX_BITS-1:0]];
  end

  // frame table: {page, dirty, load time, access time}
  logic [ENT_BITS-1:0]      rd_ent;
  logic [ENT_BITS-1:0]      wr_ent;
  logic [IDX_BITS-1:0]      frame_sel;
  logic [PAGE_NUM_BITS-1:0] ent_page;
  logic                     ent_dirty;
  logic [TIME_BITS-1:0]     ent_load;
  logic [TIME_BITS-1:0]     ent_access;

  assign {ent_page, ent_dirty, ent_load, ent_access} = rd_ent;

  prf_frame_mem #(
    .WIDTH    (ENT_BITS),
    .DEPTH    (MAX_FRAMES),
    .ADDR_BITS(IDX_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (done_fire),
    .waddr(frame_sel),
    .wdata(wr_ent),
    .raddr(issue_cnt[IDX_BITS-1:0]),
    .rdata(rd_ent)
  );

  logic [IDX_BITS-1:0]      hit_idx;
  logic                     hit_dirty;
  logic [TIME_BITS-1:0]     hit_load;
  logic [IDX_BITS-1:0]      free_idx;
  logic [IDX_BITS-1:0]      victim_idx;
  logic [PAGE_NUM_BITS-1:0] victim_page;
  logic                     victim_dirty;

  prf_scan #(
    .PAGE_BITS(PAGE_NUM_BITS),
    .TIME_BITS(TIME_BITS),
    .IDX_BITS (IDX_BITS),
    .NUM_BITS (NUM_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (scan_ctrl),
    .idx         (rd_idx),
    .occ         (occ_q),
    .ent_page    (ent_page),
    .ent_dirty   (ent_dirty),
    .ent_load    (ent_load),
    .ent_access  (ent_access),
    .page        (cur_page),
    .policy      (policy),
    .active      (active),
    .status      (scan_st),
    .hit_idx     (hit_idx),
    .hit_dirty   (hit_dirty),
    .hit_load    (hit_load),
    .free_idx    (free_idx),
    .victim_idx  (victim_idx),
    .victim_page (victim_page),
    .victim_dirty(victim_dirty)
  );

  // final step: pick the frame and build the new entry
  logic do_evict;
  always_comb begin
    do_evict = !scan_st.hit_found && !scan_st.free_found;
    if (scan_st.hit_found) begin
      frame_sel = hit_idx;
      wr_ent    = {cur_page, hit_dirty | cur_write, hit_load, clock_count};
    end else begin
      frame_sel = scan_st.free_found ? free_idx : victim_idx;
      wr_ent    = {cur_page, cur_write, clock_count, clock_count};
    end
  end

  logic [31:0] miss_count_next;
  logic [31:0] dirty_evict_count_next;
  always_comb begin
    miss_count_next        = miss_count;
    dirty_evict_count_next = dirty_evict_count;
    if (!scan_st.hit_found && (miss_count != CNT_MAX)) begin
      miss_count_next = miss_count + 32'd1;
    end
    if (do_evict && victim_dirty && (dirty_evict_count != CNT_MAX)) begin
      dirty_evict_count_next = dirty_evict_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied          <= '0;
      clock_count       <= '0;
      miss_count        <= '0;
      dirty_evict_count <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (done_fire) begin
        occupied[frame_sel] <= 1'b1;
        miss_count          <= miss_count_next;
        dirty_evict_count   <= dirty_evict_count_next;
        if (clock_count != TIME_MAX) clock_count <= clock_count + TIME_BITS'(1);
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      hit             <= scan_st.hit_found;
      frame           <= 6'(frame_sel);
      evicted         <= do_evict;
      evicted_page    <= do_evict ? 10'(victim_page) : 10'd0;
      evicted_dirty   <= do_evict && victim_dirty;
      pages_read      <= miss_count_next;
      dirty_evictions <= dirty_evict_count_next;
    end
  end

  // checks
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("accepted word did not start a scan");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (out_valid && (state == ST_IDLE)))
    else $error("final step did not present a result");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted) && (evicted || !evicted_dirty))
    else $error("eviction flags inconsistent with hit");

  a_scan_counts: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ((state == ST_SCAN) && (issue_cnt != '0)))
    else $error("entry presented outside the scan");

endmodule

// ----- verif/prf_mapping_monitor.sv -----
// Watches the input, result and register channels of the page replacement
// unit, tracks page and frame tables of its own and checks every result word.
// Depends on prf_pkg for register indexes, reset values and policy codes.
module prf_mapping_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] address,
  input  logic        is_write,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [5:0]  frame,
  input  logic        evicted,
  input  logic [9:0]  evicted_page,
  input  logic        evicted_dirty,
  input  logic [31:0] pages_read,
  input  logic [31:0] dirty_evictions,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          results_seen,
  output int          mappings_left
);
  import prf_pkg::*;

  localparam int NPAGES  = 1024;
  localparam int NFRAMES = 64;

  typedef struct packed {
    logic        hit;
    logic [5:0]  frame;
    logic        evicted;
    logic [9:0]  ev_page;
    logic        ev_dirty;
    logic [31:0] pages_read;
    logic [31:0] dirty_evictions;
  } mapping_t;

  // register copies
  logic [4:0] shift_cfg;
  logic [6:0] frames_cfg;
  logic       policy_cfg;

  // page and frame tables
  logic        pg_resident [NPAGES];
  logic        pg_dirty    [NPAGES];
  logic [5:0]  pg_frame    [NPAGES];
  logic        fr_busy     [NFRAMES];
  logic [9:0]  fr_page     [NFRAMES];
  logic [31:0] fr_loaded   [NFRAMES];
  logic [31:0] fr_touched  [NFRAMES];
  logic [31:0] stamp_clock;
  logic [31:0] miss_total;
  logic [31:0] dirty_evict_total;

  mapping_t predicted_q [$];
  int       errs = 0;
  int       seen = 0;

  assign fail_count   = errs;
  assign results_seen = seen;

  // Applies one access to the tables and returns the mapping it yields.
  function automatic mapping_t resolve_access(input logic [31:0] addr, input logic wr);
    logic [9:0]  pg;
    logic [9:0]  old;
    logic [31:0] now;
    logic [31:0] best_t;
    logic [31:0] t;
    logic        found;
    int          n;
    int          i;
    mapping_t    r;
    pg  = 10'(addr >> shift_cfg);
    now = stamp_clock;
    r   = '0;
    if (pg_resident[pg]) begin
      r.hit = 1'b1;
      r.frame = pg_frame[pg];
      if (wr) pg_dirty[pg] = 1'b1;
      fr_touched[r.frame] = now;
    end else begin
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg));
      if (miss_total != CNT_MAX) miss_total = miss_total + 1;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!found && !fr_busy[i]) begin
          r.frame = 6'(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        // oldest stamp wins, lowest frame on a tie
        r.frame = 6'd0;
        best_t = (policy_cfg == POLICY_LRU) ? fr_touched[0] : fr_loaded[0];
        for (i = 1; i < n; i++) begin
          t = (policy_cfg == POLICY_LRU) ? fr_touched[i] : fr_loaded[i];
          if (t < best_t) begin
            r.frame = 6'(i);
            best_t = t;
          end
        end
        old = fr_page[r.frame];
        r.evicted = 1'b1;
        r.ev_page = old;
        r.ev_dirty = pg_dirty[old];
        if (pg_dirty[old] && dirty_evict_total != CNT_MAX)
          dirty_evict_total = dirty_evict_total + 1;
        pg_resident[old] = 1'b0;
        pg_dirty[old] = 1'b0;
        pg_frame[old] = '0;
        fr_busy[r.frame] = 1'b0;
        fr_page[r.frame] = '0;
      end
      pg_resident[pg] = 1'b1;
      pg_dirty[pg] = wr;
      pg_frame[pg] = r.frame;
      fr_busy[r.frame] = 1'b1;
      fr_page[r.frame] = pg;
      fr_loaded[r.frame] = now;
      fr_touched[r.frame] = now;
    end
    if (stamp_clock != '1) stamp_clock = stamp_clock + 1;
    r.pages_read = miss_total;
    r.dirty_evictions = dirty_evict_total;
    return r;
  endfunction

  always @(posedge clk) begin
    mapping_t want;
    if (rst) begin
      shift_cfg  = PAGE_SHIFT_RST;
      frames_cfg = FRAME_COUNT_RST;
      policy_cfg = POLICY_FIFO;
      for (int i = 0; i < NPAGES; i++) begin
        pg_resident[i] = 1'b0;
        pg_dirty[i] = 1'b0;
        pg_frame[i] = '0;
      end
      for (int i = 0; i < NFRAMES; i++) begin
        fr_busy[i] = 1'b0;
        fr_page[i] = '0;
        fr_loaded[i] = '0;
        fr_touched[i] = '0;
      end
      stamp_clock = '0;
      miss_total = '0;
      dirty_evict_total = '0;
      predicted_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PAGE_SHIFT:  shift_cfg  = pwdata[4:0];
          REG_FRAME_COUNT: frames_cfg = pwdata[6:0];
          REG_POLICY:      policy_cfg = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (predicted_q.size() == 0) begin
          $error("result word with nothing pending: frame %0d", frame);
          errs++;
        end else begin
          want = predicted_q.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errs++;
          end
          if (frame !== want.frame) begin
            $error("frame: expected %0d, got %0d", want.frame, frame);
            errs++;
          end
          if (evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, evicted);
            errs++;
          end
          if (evicted_page !== want.ev_page) begin
            $error("evicted_page: expected %0d, got %0d", want.ev_page, evicted_page);
            errs++;
          end
          if (evicted_dirty !== want.ev_dirty) begin
            $error("evicted_dirty: expected %0d, got %0d", want.ev_dirty, evicted_dirty);
            errs++;
          end
          if (pages_read !== want.pages_read) begin
            $error("pages_read: expected %0d, got %0d", want.pages_read, pages_read);
            errs++;
          end
          if (dirty_evictions !== want.dirty_evictions) begin
            $error("dirty_evictions: expected %0d, got %0d", want.dirty_evictions,
                   dirty_evictions);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) predicted_q.push_back(resolve_access(address, is_write));
    end
    mappings_left = predicted_q.size();
  end

endmodule

// ----- verif/page_replacement_fifo_lru_test.sv -----
// Top of the page replacement unit regression: clock, reset, register writes,
// access words and result back-pressure. Depends on prf_pkg, the block itself
// and prf_mapping_monitor, which predicts and checks every result word.
module page_replacement_fifo_lru_test;
  import prf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [31:0] address;
  logic is_write;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic [5:0] frame;
  logic evicted;
  logic [9:0] evicted_page;
  logic evicted_dirty;
  logic [31:0] pages_read;
  logic [31:0] dirty_evictions;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int fail_count;
  int results_seen;
  int mappings_left;
  int words_sent = 0;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  page_replacement_fifo_lru dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .address(address), .is_write(is_write),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .frame(frame),
    .evicted(evicted), .evicted_page(evicted_page), .evicted_dirty(evicted_dirty),
    .pages_read(pages_read), .dirty_evictions(dirty_evictions),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  prf_mapping_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .address(address), .is_write(is_write),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .frame(frame),
    .evicted(evicted), .evicted_page(evicted_page), .evicted_dirty(evicted_dirty),
    .pages_read(pages_read), .dirty_evictions(dirty_evictions),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .results_seen(results_seen), .mappings_left(mappings_left)
  );

  task automatic send_word(input logic [31:0] a, input logic w);
    int g;
    g = gaps_on ? $urandom_range(0, 13) : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    is_write <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits carry junk; the block keeps only the register width.
  task automatic set_config(input logic [4:0] sh, input logic [6:0] fc, input logic pol);
    wait_drained();
    apb_write(REG_PAGE_SHIFT,  (32'($urandom) & 32'hFFFF_FFE0) | 32'(sh));
    apb_write(REG_FRAME_COUNT, (32'($urandom) & 32'hFFFF_FF80) | 32'(fc));
    apb_write(REG_POLICY,      (32'($urandom) & 32'hFFFF_FFFE) | 32'(pol));
  endtask

  // result side back-pressure
  initial begin
    int g;
    logic held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        g = 600;
        held = 1'b1;
      end else begin
        g = gaps_on ? $urandom_range(0, 13) : 0;
      end
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [4:0]  sh;
    logic [6:0]  fc;
    logic        pol;
    logic [9:0]  pool [80];
    logic [31:0] a;
    logic [31:0] m;
    int          eff;
    int          k;
    int          n;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    address  <= '0;
    is_write <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two frames, no shift, oldest load goes: dirty evictions, top page
    set_config(5'd0, 7'd2, POLICY_FIFO);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0002, 1'b1);
    send_word(32'h0000_03FF, 1'b0);
    send_word(32'h0000_0000, 1'b0);

    // frame count zero acts as one; widest shift leaves one page bit
    set_config(5'd31, 7'd0, POLICY_LRU);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);

    // count above the frame store clamps to all frames
    set_config(5'd24, 7'd127, POLICY_LRU);
    send_word(32'hFF00_0000, 1'b1);
    send_word(32'h00FF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    send_word(32'hFF12_3456, 1'b0);

    // shrink to three frames; LRU evicts the page untouched longest
    set_config(5'd10, 7'd3, POLICY_LRU);
    send_word(32'h0000_1400, 1'b0);
    send_word(32'h0000_1800, 1'b1);
    send_word(32'h0000_1C00, 1'b0);
    send_word(32'h0000_1400, 1'b0);
    send_word(32'h0000_2000, 1'b1);
    send_word(32'h0000_1800, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin sh = 5'd10; fc = 7'd64;  pol = POLICY_LRU;  end
        1: begin sh = 5'd24; fc = 7'd1;   pol = POLICY_FIFO; end
        2: begin sh = 5'd0;  fc = 7'd0;   pol = POLICY_LRU;  end
        3: begin sh = 5'd31; fc = 7'd127; pol = POLICY_FIFO; end
        default: begin
          sh  = 5'($urandom_range(10, 24));
          fc  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(9, 64))
                                            : 7'($urandom_range(1, 8));
          pol = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(sh, fc, pol);
      gaps_on = (ph % 4 != 1);
      if (ph == 5) hold_req = 1'b1;
      eff = (fc == 0) ? 1 : ((fc > 64) ? 64 : int'(fc));
      // working set a little larger than the frames: hits and evictions both
      k = eff + $urandom_range(1, 6);
      for (int i = 0; i < k; i++) pool[i] = 10'($urandom);
      n = $urandom_range(90, 150);
      for (int j = 0; j < n; j++) begin
        a = $urandom;
        if ($urandom_range(0, 6) != 0) begin
          m = 32'h3FF << sh;
          a = (a & ~m) | ((32'(pool[$urandom_range(0, k - 1)]) << sh) & m);
        end
        send_word(a, 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && mappings_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
